// ===== sv/fpjs_pkg.sv =====
// ----------------------------------------------------------------------------
// fpjs_pkg
// Shared types and constants for the FIFO-fed priority job stack: command
// and status codes, field widths and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fpjs_pkg;

    // Default sizing for the top level and datapath parameters
    localparam int DEPTH_DEF      = 16;
    localparam int ID_WIDTH_DEF   = 16;
    localparam int PRIO_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int MOVED_W  = 5;

    // Command codes on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_XFER = 2'd1,
        CMD_EXEC = 2'd2
    } cmd_e_t;

    // Result kinds on m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED  = 3'd0,
        STS_REJECT = 3'd1,
        STS_MOVED  = 3'd2,
        STS_EXEC   = 3'd3,
        STS_NONE   = 3'd4
    } status_e_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic      cap_in;       // latch the input job
        logic      fifo_push;    // write latched job at the FIFO tail
        logic      fifo_rd;      // read the FIFO head
        logic      fifo_pop;     // take the head word as the job to insert
        logic      clr_moved;    // start of a transfer
        logic      sort_rd_up;   // read the store entry above the insert slot
        logic      sort_shift;   // move that entry down one slot
        logic      sort_place;   // drop the job into the insert slot
        logic      exec_start;   // point at the top of the store
        logic      exec_rd;      // read the store at the pointer
        logic      exec_next;    // advance the pointer
        logic      sort_clr;     // store emptied after execute
        logic      emit;         // load the output register
        status_e_t emit_status;
        logic      emit_last;
    } ctrl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic fifo_full;
        logic fifo_empty;
        logic sort_full;
        logic sort_empty;
        logic idx_zero;      // insert slot at the top
        logic shift_needed;  // entry above has lower priority than the job
        logic exec_last;     // pointer at the bottom entry
        logic out_free;      // output register can take a word
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/fifo_fed_priority_job_stack.sv =====
// ----------------------------------------------------------------------------
// fifo_fed_priority_job_stack
// Two-stage job scheduler: arrival FIFO feeding a priority-sorted store.
// ----------------------------------------------------------------------------
// One command word is taken at a time. A transfer moves jobs from the FIFO
// head one by one; each job walks up from the bottom of the sorted store,
// with one store read and one shift for every stored entry of lower
// priority that the job passes, and stops at the top of the store or under
// a stored entry. The sorted store has a single read and a single write
// port. An execute makes one store read and one output load per stored
// job, or gives a none result when the store is empty. An unused command
// code gives no result. The output word sits in a register, so the next
// command is taken while the last result still waits on m_tready; a
// stalled output stalls the execute walk, not the insertion walk.
// Equal priorities keep arrival order; adds to a full FIFO are echoed with a
// reject status.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_fed_priority_job_stack #(
    parameter int DEPTH      = fpjs_pkg::DEPTH_DEF,
    parameter int ID_WIDTH   = fpjs_pkg::ID_WIDTH_DEF,
    parameter int PRIO_WIDTH = fpjs_pkg::PRIO_WIDTH_DEF,
    localparam int S_TDATA_W = ((ID_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W =
        ((ID_WIDTH + PRIO_WIDTH + fpjs_pkg::MOVED_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command word in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [S_TDATA_W-1:0]          s_tdata,  // job_id, job_priority, zero pad
    input  wire logic [fpjs_pkg::CMD_W-1:0]    s_tuser,  // cmd
    // result word out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,  // out_job_id, out_job_priority,
                                                         // moved_count, zero pad
    output logic [fpjs_pkg::STATUS_W-1:0]      m_tuser,  // status
    output logic                               m_tlast   // last
);

    fpjs_pkg::ctrl_t ctrl;
    fpjs_pkg::stat_t stat;

    logic [ID_WIDTH-1:0]            out_id;
    logic [PRIO_WIDTH-1:0]          out_prio;
    logic [fpjs_pkg::MOVED_W-1:0]   out_moved;

    fpjs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .cmd      (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    fpjs_dp #(
        .DEPTH      (DEPTH),
        .ID_WIDTH   (ID_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_id      (s_tdata[ID_WIDTH-1:0]),
        .in_prio    (s_tdata[ID_WIDTH +: PRIO_WIDTH]),
        .ctrl       (ctrl),
        .stat       (stat),
        .m_tready   (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_id     (out_id),
        .out_prio   (out_prio),
        .out_moved  (out_moved),
        .out_last   (m_tlast)
    );

    // Pack the result word
    assign m_tdata = M_TDATA_W'({out_moved, out_prio, out_id});

    // A result is never loaded over one still waiting
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> (!m_tvalid || m_tready))
        else $error("output word overwritten");

    // No push into a full arrival FIFO
    a_push_not_full : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fifo_push |-> !stat.fifo_full)
        else $error("push into full arrival FIFO");

    // No insertion into a full sorted store
    a_place_not_full : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.sort_place |-> !stat.sort_full)
        else $error("insert into full sorted store");

    // Execute leaves the store empty
    a_exec_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.sort_clr |=> stat.sort_empty)
        else $error("store not empty after execute");

endmodule

`default_nettype wire

// ===== sv/fpjs_dp.sv =====
// ----------------------------------------------------------------------------
// fpjs_dp
// Datapath: arrival FIFO memory with head/tail/count, sorted store memory
// with occupancy and walk pointer, job latch, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fpjs_dp #(
    parameter int DEPTH      = fpjs_pkg::DEPTH_DEF,
    parameter int ID_WIDTH   = fpjs_pkg::ID_WIDTH_DEF,
    parameter int PRIO_WIDTH = fpjs_pkg::PRIO_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ID_WIDTH-1:0]           in_id,
    input  wire logic [PRIO_WIDTH-1:0]         in_prio,
    input  wire fpjs_pkg::ctrl_t               ctrl,
    output fpjs_pkg::stat_t                    stat,
    input  wire logic                          m_tready,
    output logic                               out_valid,
    output logic [fpjs_pkg::STATUS_W-1:0]      out_status,
    output logic [ID_WIDTH-1:0]                out_id,
    output logic [PRIO_WIDTH-1:0]              out_prio,
    output logic [fpjs_pkg::MOVED_W-1:0]       out_moved,
    output logic                               out_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [PRIO_WIDTH-1:0] prio;
        logic [ID_WIDTH-1:0]   id;
    } job_t;

    // Storage
    job_t fifo_mem [DEPTH];
    job_t sort_mem [DEPTH];

    job_t             job_reg;
    job_t             fifo_q_reg;
    job_t             sort_q_reg;
    logic [IDX_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] fcount_reg;
    logic [CNT_W-1:0] scount_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] moved_reg;

    logic [IDX_W-1:0] head_next, tail_next;
    logic [IDX_W-1:0] sort_waddr, sort_raddr;
    job_t             sort_wdata;

    // Output register
    logic                         valid_reg;
    logic [fpjs_pkg::STATUS_W-1:0] status_reg;
    job_t                         out_job_reg;
    logic [CNT_W-1:0]             out_moved_reg;
    logic                         last_reg;

    // Circular index increments
    assign head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // FIFO memory port
    always_ff @(posedge aclk) begin
        if (ctrl.fifo_push) begin
            fifo_mem[tail_reg] <= job_reg;
        end
        if (ctrl.fifo_rd) begin
            fifo_q_reg <= fifo_mem[head_reg];
        end
    end

    // Sorted store port: one write, one read per cycle
    assign sort_waddr = idx_reg;
    assign sort_wdata = ctrl.sort_shift ? sort_q_reg : job_reg;
    assign sort_raddr = ctrl.sort_rd_up ? idx_reg - 1'b1 : idx_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.sort_shift || ctrl.sort_place) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        if (ctrl.sort_rd_up || ctrl.exec_rd) begin
            sort_q_reg <= sort_mem[sort_raddr];
        end
    end

    // Job latch
    always_ff @(posedge aclk) begin
        if (ctrl.cap_in) begin
            job_reg <= '{prio: in_prio, id: in_id};
        end else if (ctrl.fifo_pop) begin
            job_reg <= fifo_q_reg;
        end
    end

    // Pointers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fcount_reg <= '0;
            scount_reg <= '0;
            idx_reg    <= '0;
            moved_reg  <= '0;
        end else begin
            if (ctrl.fifo_push) begin
                tail_reg   <= tail_next;
                fcount_reg <= fcount_reg + 1'b1;
            end
            if (ctrl.fifo_pop) begin
                head_reg   <= head_next;
                fcount_reg <= fcount_reg - 1'b1;
                moved_reg  <= moved_reg + 1'b1;
                idx_reg    <= scount_reg[IDX_W-1:0];
            end
            if (ctrl.clr_moved) begin
                moved_reg <= '0;
            end
            if (ctrl.sort_shift) begin
                idx_reg <= idx_reg - 1'b1;
            end
            if (ctrl.sort_place) begin
                scount_reg <= scount_reg + 1'b1;
            end
            if (ctrl.exec_start) begin
                idx_reg <= '0;
            end
            if (ctrl.exec_next) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctrl.sort_clr) begin
                scount_reg <= '0;
            end
        end
    end

    // Output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload by result kind
    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            status_reg <= ctrl.emit_status;
            last_reg   <= ctrl.emit_last;
            case (ctrl.emit_status)
                fpjs_pkg::STS_ADDED, fpjs_pkg::STS_REJECT: begin
                    out_job_reg   <= job_reg;
                    out_moved_reg <= '0;
                end
                fpjs_pkg::STS_MOVED: begin
                    out_job_reg   <= '0;
                    out_moved_reg <= moved_reg;
                end
                fpjs_pkg::STS_EXEC: begin
                    out_job_reg   <= sort_q_reg;
                    out_moved_reg <= '0;
                end
                default: begin
                    out_job_reg   <= '0;
                    out_moved_reg <= '0;
                end
            endcase
        end
    end

    // Status back to the controller
    assign stat.fifo_full    = (fcount_reg == CNT_W'(DEPTH));
    assign stat.fifo_empty   = (fcount_reg == '0);
    assign stat.sort_full    = (scount_reg == CNT_W'(DEPTH));
    assign stat.sort_empty   = (scount_reg == '0);
    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.shift_needed = (sort_q_reg.prio < job_reg.prio);
    assign stat.exec_last    = ((CNT_W'(idx_reg) + 1'b1) == scount_reg);
    assign stat.out_free     = !valid_reg || m_tready;

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_id     = out_job_reg.id;
    assign out_prio   = out_job_reg.prio;
    assign out_moved  = fpjs_pkg::MOVED_W'(out_moved_reg);
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// ===== sv/fpjs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpjs_ctrl
// Controller: one-hot state machine sequencing add, transfer (insertion
// walk per job) and execute (pop walk) over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fpjs_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    input  wire logic [fpjs_pkg::CMD_W-1:0] cmd,
    output logic                            s_tready,
    input  wire fpjs_pkg::stat_t            stat,
    output fpjs_pkg::ctrl_t                 ctrl
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_ADD   = 11'b000_0000_0010,
        ST_XCHK  = 11'b000_0000_0100,
        ST_XLOAD = 11'b000_0000_1000,
        ST_IRD   = 11'b000_0001_0000,
        ST_ICMP  = 11'b000_0010_0000,
        ST_XDONE = 11'b000_0100_0000,
        ST_ECHK  = 11'b000_1000_0000,
        ST_ERD   = 11'b001_0000_0000,
        ST_EEMIT = 11'b010_0000_0000,
        ST_ENONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next       = state_reg;
        ctrl             = '0;
        ctrl.emit_status = fpjs_pkg::STS_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.cap_in = 1'b1;
                    unique case (fpjs_pkg::cmd_e_t'(cmd))
                        fpjs_pkg::CMD_ADD:  state_next = ST_ADD;
                        fpjs_pkg::CMD_XFER: begin
                            ctrl.clr_moved = 1'b1;
                            state_next     = ST_XCHK;
                        end
                        fpjs_pkg::CMD_EXEC: state_next = ST_ECHK;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD: begin
                if (stat.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.emit_status = stat.fifo_full ? fpjs_pkg::STS_REJECT
                                                      : fpjs_pkg::STS_ADDED;
                    ctrl.fifo_push   = !stat.fifo_full;
                    state_next       = ST_IDLE;
                end
            end
            // transfer loop: one job per pass
            ST_XCHK: begin
                if (stat.fifo_empty || stat.sort_full) begin
                    state_next = ST_XDONE;
                end else begin
                    ctrl.fifo_rd = 1'b1;
                    state_next   = ST_XLOAD;
                end
            end
            ST_XLOAD: begin
                ctrl.fifo_pop = 1'b1;
                state_next    = ST_IRD;
            end
            // insertion walk from the bottom up
            ST_IRD: begin
                if (stat.idx_zero) begin
                    ctrl.sort_place = 1'b1;
                    state_next      = ST_XCHK;
                end else begin
                    ctrl.sort_rd_up = 1'b1;
                    state_next      = ST_ICMP;
                end
            end
            ST_ICMP: begin
                if (stat.shift_needed) begin
                    ctrl.sort_shift = 1'b1;
                    state_next      = ST_IRD;
                end else begin
                    ctrl.sort_place = 1'b1;
                    state_next      = ST_XCHK;
                end
            end
            ST_XDONE: begin
                if (stat.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.emit_status = fpjs_pkg::STS_MOVED;
                    state_next       = ST_IDLE;
                end
            end
            // execute: pop top to bottom
            ST_ECHK: begin
                if (stat.sort_empty) begin
                    state_next = ST_ENONE;
                end else begin
                    ctrl.exec_start = 1'b1;
                    state_next      = ST_ERD;
                end
            end
            ST_ERD: begin
                ctrl.exec_rd = 1'b1;
                state_next   = ST_EEMIT;
            end
            ST_EEMIT: begin
                if (stat.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = stat.exec_last;
                    ctrl.emit_status = fpjs_pkg::STS_EXEC;
                    if (stat.exec_last) begin
                        ctrl.sort_clr = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        ctrl.exec_next = 1'b1;
                        state_next     = ST_ERD;
                    end
                end
            end
            ST_ENONE: begin
                if (stat.out_free) begin
                    ctrl.emit        = 1'b1;
                    ctrl.emit_last   = 1'b1;
                    ctrl.emit_status = fpjs_pkg::STS_NONE;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO-fed priority job stack. Command words are
// streamed in with random gaps. A scoreboard keeps its own arrival queue and
// sorted store and builds the expected result words for every accepted
// command. Each result word is compared field by field with the oldest
// expected word. A long output stall is forced once so the block fills up
// and pushes back on its input.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int DEPTH       = fpjs_pkg::DEPTH_DEF;
    localparam int ID_W        = fpjs_pkg::ID_WIDTH_DEF;
    localparam int PRIO_W      = fpjs_pkg::PRIO_WIDTH_DEF;
    localparam int CMD_W       = fpjs_pkg::CMD_W;
    localparam int STATUS_W    = fpjs_pkg::STATUS_W;
    localparam int MOVED_W     = fpjs_pkg::MOVED_W;
    localparam int S_W         = ((ID_W + PRIO_W + 7) / 8) * 8;
    localparam int M_W         = ((ID_W + PRIO_W + MOVED_W + 7) / 8) * 8;
    localparam int RANDOM_JOBS = 290;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 64;

    // code 3 is not a command; the block drops it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // priority spread used by a batch of random words
    localparam int PRI_ANY  = 0;
    localparam int PRI_TIES = 1;
    localparam int PRI_TOP  = 2;

    // directed adds: field extremes plus several equal priorities
    localparam logic [ID_W-1:0] DIR_IDS [DEPTH] = '{
        16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA,
        16'h0001, 16'h7FFF, 16'h8000, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h6996};
    localparam logic [PRIO_W-1:0] DIR_PRIOS [DEPTH] = '{
        8'h00, 8'hFF, 8'h80, 8'h80, 8'h01, 8'hFE, 8'h80, 8'h00,
        8'hFF, 8'h7F, 8'h80, 8'h10, 8'hEF, 8'h40, 8'hBF, 8'h80};

    typedef struct {
        fpjs_pkg::status_e_t status;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   prio;
        logic [MOVED_W-1:0]  moved;
        logic                last;
    } job_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: arrival queue and sorted store, expected result words
    // ------------------------------------------------------------------------
    class job_stack_scoreboard;
        logic [ID_W-1:0]   arrival_id [DEPTH];
        logic [PRIO_W-1:0] arrival_prio [DEPTH];
        int                arrival_rd;
        int                arrival_wr;
        int                arrival_used;
        logic [ID_W-1:0]   stack_id [DEPTH];
        logic [PRIO_W-1:0] stack_prio [DEPTH];
        int                stack_used;
        job_result_t       expected_words [$];
        int                error_count;

        function new();
            arrival_rd   = 0;
            arrival_wr   = 0;
            arrival_used = 0;
            stack_used   = 0;
            error_count  = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void expect_word(fpjs_pkg::status_e_t st, logic [ID_W-1:0] id,
                                  logic [PRIO_W-1:0] pr, int moved, logic last);
            job_result_t w;
            w.status = st;
            w.id     = id;
            w.prio   = pr;
            w.moved  = MOVED_W'(moved);
            w.last   = last;
            expected_words.push_back(w);
        endfunction

        // equal priority lands below the jobs already stored
        function void insert_sorted(logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
            int slot;
            slot = 0;
            while (slot < stack_used && stack_prio[slot] >= pr)
                slot++;
            for (int i = stack_used; i > slot; i--) begin
                stack_id[i]   = stack_id[i-1];
                stack_prio[i] = stack_prio[i-1];
            end
            stack_id[slot]   = id;
            stack_prio[slot] = pr;
            stack_used++;
        endfunction

        // one accepted command word
        function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                   logic [PRIO_W-1:0] pr);
            int moved;
            if (cmd == fpjs_pkg::CMD_ADD) begin
                if (arrival_used >= DEPTH) begin
                    expect_word(fpjs_pkg::STS_REJECT, id, pr, 0, 1'b1);
                end else begin
                    arrival_id[arrival_wr]   = id;
                    arrival_prio[arrival_wr] = pr;
                    arrival_wr = (arrival_wr + 1) % DEPTH;
                    arrival_used++;
                    expect_word(fpjs_pkg::STS_ADDED, id, pr, 0, 1'b1);
                end
            end else if (cmd == fpjs_pkg::CMD_XFER) begin
                moved = 0;
                while (arrival_used > 0 && stack_used < DEPTH) begin
                    insert_sorted(arrival_id[arrival_rd], arrival_prio[arrival_rd]);
                    arrival_rd = (arrival_rd + 1) % DEPTH;
                    arrival_used--;
                    moved++;
                end
                expect_word(fpjs_pkg::STS_MOVED, '0, '0, moved, 1'b1);
            end else if (cmd == fpjs_pkg::CMD_EXEC) begin
                if (stack_used == 0) begin
                    expect_word(fpjs_pkg::STS_NONE, '0, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < stack_used; i++)
                        expect_word(fpjs_pkg::STS_EXEC, stack_id[i], stack_prio[i], 0,
                                    i == stack_used - 1);
                    stack_used = 0;
                end
            end
        endfunction

        task report(string msg);
            if (error_count < 200)
                $display("[%0t] ERROR: %s", $realtime, msg);
            error_count++;
        endtask

        task check_word(logic [STATUS_W-1:0] st, logic [ID_W-1:0] id,
                        logic [PRIO_W-1:0] pr, logic [MOVED_W-1:0] moved, logic last);
            job_result_t want;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected result word status=%0d id=%h prio=%h",
                                 st, id, pr));
                return;
            end
            want = expected_words.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, wanted %s", st, want.status.name()));
            if (id !== want.id)
                report($sformatf("job id %h, wanted %h (%s)", id, want.id,
                                 want.status.name()));
            if (pr !== want.prio)
                report($sformatf("job priority %h, wanted %h (%s)", pr, want.prio,
                                 want.status.name()));
            if (moved !== want.moved)
                report($sformatf("moved count %0d, wanted %0d", moved, want.moved));
            if (last !== want.last)
                report($sformatf("last flag %b, wanted %b (%s)", last, want.last,
                                 want.status.name()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata  = '0;
    logic [CMD_W-1:0] s_tuser  = fpjs_pkg::CMD_ADD;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic             m_tlast;

    fifo_fed_priority_job_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    job_stack_scoreboard board = new();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_gap      = 0;
    logic hold_off    = 1'b0;
    bit random_phase  = 1'b0;
    int jobs_sent     = 0;
    int cycle_count   = 0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio(int spread);
        case (spread)
            PRI_TIES: return PRIO_W'($urandom_range(0, 3));
            PRI_TOP:  return PRIO_W'($urandom_range(252, 255));
            default:  return PRIO_W'($urandom_range(0, 255));
        endcase
    endfunction

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("fifo_fed_priority_job_stack: mismatch");
            $finish;
        end
    end

    // result side: check accepted words, then pick the next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_word(m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W +: PRIO_W],
                             m_tdata[ID_W+PRIO_W +: MOVED_W], m_tlast);
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < sink_idle_pct)
                sink_gap <= pick_gap();
        end
    end

    // one long output stall while commands keep coming
    initial begin
        wait (random_phase);
        repeat (40) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (500) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // offer one command word and wait for it to be taken
    task send_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
        int gap;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_W'({pr, id});
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, id, pr);
        jobs_sent++;
    endtask

    task send_random(logic [CMD_W-1:0] cmd, int spread);
        send_word(cmd, ID_W'($urandom_range(0, 65535)), pick_prio(spread));
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int roll;
        int spread;
        int burst;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty block: execute with nothing stored, transfer of nothing,
        // then a word with the unused command code
        send_word(fpjs_pkg::CMD_EXEC, '0, '0);
        send_word(fpjs_pkg::CMD_XFER, '0, '0);
        send_word(CMD_UNUSED, 16'hBEEF, 8'hA5);

        // fill the arrival queue, then one add too many
        for (int i = 0; i < DEPTH; i++)
            send_word(fpjs_pkg::CMD_ADD, DIR_IDS[i], DIR_PRIOS[i]);
        send_word(fpjs_pkg::CMD_ADD, 16'hA5A5, 8'h5A);

        // move all into the store; a transfer into a full store moves nothing
        send_word(fpjs_pkg::CMD_XFER, '0, '0);
        send_word(fpjs_pkg::CMD_ADD, 16'h4242, 8'hFF);
        send_word(fpjs_pkg::CMD_XFER, '0, '0);
        send_word(fpjs_pkg::CMD_EXEC, '0, '0);
        send_word(fpjs_pkg::CMD_XFER, '0, '0);
        send_word(fpjs_pkg::CMD_EXEC, '0, '0);

        // random batches: mixed traffic, or fill-and-drain bursts
        jobs_sent = 0;
        random_phase = 1'b1;
        while (jobs_sent < RANDOM_JOBS) begin
            spread = $urandom_range(PRI_ANY, PRI_TOP);
            if ($urandom_range(0, 3) == 0)
                spread = PRI_ANY;
            src_idle_pct  = pick_idle();
            sink_idle_pct <= pick_idle();
            if ($urandom_range(0, 99) < 35) begin
                burst = $urandom_range(8, 20);
                repeat (burst) send_random(fpjs_pkg::CMD_ADD, spread);
                send_random(fpjs_pkg::CMD_XFER, spread);
                if ($urandom_range(0, 1))
                    send_random(fpjs_pkg::CMD_XFER, spread);
                if ($urandom_range(0, 9) < 6)
                    send_random(fpjs_pkg::CMD_EXEC, spread);
            end else begin
                repeat (12) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50)
                        send_random(fpjs_pkg::CMD_ADD, spread);
                    else if (roll < 70)
                        send_random(fpjs_pkg::CMD_XFER, spread);
                    else if (roll < 92)
                        send_random(fpjs_pkg::CMD_EXEC, spread);
                    else
                        send_random(CMD_UNUSED, PRI_ANY);
                end
            end
        end

        // flush what is left in both stages
        send_random(fpjs_pkg::CMD_XFER, PRI_ANY);
        send_random(fpjs_pkg::CMD_EXEC, PRI_ANY);
        send_random(fpjs_pkg::CMD_XFER, PRI_ANY);
        send_random(fpjs_pkg::CMD_EXEC, PRI_ANY);
        s_tvalid <= 1'b0;
        sink_idle_pct <= 0;

        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.error_count == 0)
            $display("fifo_fed_priority_job_stack: match");
        else
            $display("fifo_fed_priority_job_stack: mismatch");
        $finish;
    end

endmodule
